// ===== hw/rtl/b64se_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64se_pkg: shared types and constants for the base64 stream encoder
// Item structs, the queued group record and the character lookup.
// ----------------------------------------------------------------------------
package b64se_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QPtrW      = $clog2(QueueDepth);
    localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

    localparam logic [7:0] PadChar = 8'h3d;

    // Input item: one raw byte and its end-of-message flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    // Output item: one character with its markers
    typedef struct packed {
        logic [7:0] text_char;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    // One complete or zero-filled group waiting to be encoded
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;   // 1..3 bytes of real data
        logic        fin;
    } t_group;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Map a 6-bit index to its alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'h41 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'h61 + {2'b00, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            c = 8'h30 + {2'b00, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64se_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64se_front: byte collector
// Accepts raw bytes, holds up to two, and pushes a group on the third byte
// or on the final byte of a message.
// ----------------------------------------------------------------------------
module b64se_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  b64se_pkg::t_in_item  i_in_item,
    input  b64se_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output b64se_pkg::t_group    o_push_group
);

    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_cnt, n_cnt;
    logic       accept;
    logic       two_held;

    // Stall while the queue has no room
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign two_held   = r_cnt[1];

    // Build the group and update the held bytes
    always_comb begin
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_push_group.bits   = '0;
        o_push_group.nbytes = 2'd1;
        o_push_group.fin    = i_in_item.is_final;
        if (two_held) begin
            o_push_group.bits   = {r_held0, r_held1, i_in_item.data_byte};
            o_push_group.nbytes = 2'd3;
        end else if (r_cnt == 2'd1) begin
            o_push_group.bits   = {r_held0, i_in_item.data_byte, 8'h00};
            o_push_group.nbytes = 2'd2;
        end else begin
            o_push_group.bits   = {i_in_item.data_byte, 16'h0000};
            o_push_group.nbytes = 2'd1;
        end
        if (accept) begin
            if (!two_held && !i_in_item.is_final) begin
                if (r_cnt == 2'd0) begin
                    n_held0 = i_in_item.data_byte;
                end else begin
                    n_held1 = i_in_item.data_byte;
                end
                n_cnt = r_cnt + 2'd1;
            end else begin
                o_push  = 1'b1;
                n_held0 = 8'h00;
                n_held1 = 8'h00;
                n_cnt   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("held byte count out of range");

endmodule

// ===== hw/rtl/b64se_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64se_queue: group queue
// Short first-in first-out queue between byte collector and emitter.
// ----------------------------------------------------------------------------
module b64se_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64se_pkg::t_group    i_push_group,
    input  logic                 i_pop,
    output b64se_pkg::t_group    o_head,
    output b64se_pkg::t_q_status o_status
);

    b64se_pkg::t_group                  r_mem [b64se_pkg::QueueDepth];
    logic [b64se_pkg::QPtrW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [b64se_pkg::QPtrW-1:0]        r_rd_ptr, n_rd_ptr;
    logic [b64se_pkg::QCntW-1:0]        r_count, n_count;

    assign o_status.full  = (r_count == b64se_pkg::QCntW'(b64se_pkg::QueueDepth));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == b64se_pkg::QPtrW'(b64se_pkg::QueueDepth - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == b64se_pkg::QPtrW'(b64se_pkg::QueueDepth - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_group;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/b64se_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64se_back: character emitter
// Takes the queue head and sends its four characters, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module b64se_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64se_pkg::t_group    i_head,
    input  b64se_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output b64se_pkg::t_out_item o_out_item
);

    logic [1:0]           r_k, n_k;
    logic                 r_valid, n_valid;
    b64se_pkg::t_out_item r_item, n_item;
    logic                 load;
    logic [5:0]           idx;

    // Load the output stage whenever it is empty or being taken and the queue holds a group
    assign load = (!r_valid || !i_out_stall) && !i_q_status.empty;

    always_comb begin
        case (r_k)
            2'd0:    idx = i_head.bits[23:18];
            2'd1:    idx = i_head.bits[17:12];
            2'd2:    idx = i_head.bits[11:6];
            default: idx = i_head.bits[5:0];
        endcase
    end

    // Select character or pad, advance the character index
    always_comb begin
        n_k     = r_k;
        n_valid = r_valid && i_out_stall;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            n_item.text_char   = (r_k <= i_head.nbytes) ? b64se_pkg::b64_char(idx)
                                                        : b64se_pkg::PadChar;
            n_item.run_last    = (r_k == 2'd3);
            n_item.message_end = (r_k == 2'd3) && i_head.fin;
            n_k = r_k + 2'd1;
            if (r_k == 2'd3) begin
                o_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_k     <= n_k;
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.message_end) |-> r_item.run_last)
        else $error("message end on a character that is not the last of its group");

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder, standard alphabet
// Turns raw bytes into base64 characters with '=' padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one byte per
//   item with a flag on the last byte of a message. Output channel
//   (o_out_valid / i_out_stall / o_out_item) gives one character per item.
//   Every third byte, or a final byte, yields four characters; run_last
//   marks the fourth, message_end marks the fourth of the final group.
//   A group is written into the group queue when the byte that completes
//   it is accepted; its characters then leave through the emitter's output register.
//   Throughput: one character per cycle from the emitter while the output
//   is not stalled; the input stalls only when the two-entry group queue
//   is full.
//   Reset (synchronous, active low) drops held bytes, empties the queue
//   and clears the output stage. When the receiver stalls the output
//   character holds; the queue then fills and the input stalls in turn.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  b64se_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output b64se_pkg::t_out_item o_out_item
);

    logic                 push;
    logic                 pop;
    b64se_pkg::t_group    push_group;
    b64se_pkg::t_group    head;
    b64se_pkg::t_q_status q_status;

    b64se_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_push_group (push_group)
    );

    b64se_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_group (push_group),
        .i_pop        (pop),
        .o_head       (head),
        .o_status     (q_status)
    );

    b64se_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
